// ----- rtl/bdq_pkg.sv -----
package bdq_pkg;

   localparam int DEF_DEPTH      = 16;
   localparam int DEF_DATA_WIDTH = 32;

   // Widths of the channel fields.
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_TAIL = 3'd0,
      ACT_PUSH_HEAD = 3'd1,
      ACT_POP_HEAD  = 3'd2,
      ACT_POP_TAIL  = 3'd3,
      ACT_DELETE    = 3'd4,
      ACT_READ      = 3'd5,
      ACT_FIND      = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  read_data;
      logic                found;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } result_type;

endpackage

// ----- rtl/bdq_mem.sv -----
module bdq_mem #(
   parameter int DEPTH = bdq_pkg::DEF_DEPTH,
   parameter int WIDTH = bdq_pkg::DEF_DATA_WIDTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/bdq_ctrl.sv -----
module bdq_ctrl #(
   parameter int DEPTH = bdq_pkg::DEF_DEPTH,
   parameter int SW    = bdq_pkg::DEF_DATA_WIDTH,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bdq_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_value,
   input  logic [bdq_pkg::INDEX_W-1:0]        req_index,
   output logic                               busy,
   output logic                               done,
   output bdq_pkg::result_type                result,
   output logic                               mem_wr_en,
   output logic [PW-1:0]                      mem_wr_addr,
   output logic [SW-1:0]                      mem_wr_data,
   output logic                               mem_rd_en,
   output logic [PW-1:0]                      mem_rd_addr,
   input  logic [SW-1:0]                      mem_rd_data
);

   localparam int IW = (CW > bdq_pkg::INDEX_W) ? CW : bdq_pkg::INDEX_W;

   bdq_pkg::state_type  state_ff, state_in;
   logic [PW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       val_ff, val_in;
   logic                is_del_ff, is_del_in;
   logic [CW-1:0]       rd_pos_ff, rd_pos_in;
   logic                pend_ff, pend_in;
   logic [PW-1:0]       cmp_pos_ff, cmp_pos_in;
   logic [CW-1:0]       k_ff, k_in;

   bdq_pkg::action_type act;
   logic                full, empty, idx_ok, match, last, scan_done;
   logic [PW-1:0]       head_m1, head_p1;
   logic [PW-1:0]       wr_pos, rd_pos;

   // Ring slot of a position counted from the head.
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] h, input logic [PW-1:0] p);
      logic [PW:0] s;
      s = {1'b0, h} + {1'b0, p};
      if (s >= (PW+1)'(DEPTH)) begin
         s = s - (PW+1)'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   assign act       = bdq_pkg::action_type'(req_action);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign idx_ok    = (IW'(req_index) < IW'(count_ff));
   assign head_m1   = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - PW'(1);
   assign head_p1   = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
   assign match     = (mem_rd_data == val_ff);
   assign last      = ((CW'(cmp_pos_ff) + CW'(1)) == count_ff);
   assign scan_done = pend_ff && (last || (!is_del_ff && match));
   assign busy      = (state_ff != bdq_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (start) begin
               if (act == bdq_pkg::ACT_READ && idx_ok) begin
                  state_in = bdq_pkg::S_READ;
               end else if ((act == bdq_pkg::ACT_DELETE || act == bdq_pkg::ACT_FIND)
                            && !empty) begin
                  state_in = bdq_pkg::S_SCAN;
               end
            end
         end
         bdq_pkg::S_READ: state_in = bdq_pkg::S_IDLE;
         bdq_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = bdq_pkg::S_IDLE;
            end
         end
         default: state_in = bdq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      val_in     = val_ff;
      is_del_in  = is_del_ff;
      rd_pos_in  = rd_pos_ff;
      pend_in    = pend_ff;
      cmp_pos_in = cmp_pos_ff;
      k_in       = k_ff;
      wr_pos     = k_ff[PW-1:0];
      rd_pos     = rd_pos_ff[PW-1:0];
      mem_wr_en  = 1'b0;
      mem_wr_data = mem_rd_data;
      mem_rd_en  = 1'b0;
      done       = 1'b0;
      result     = '{status: bdq_pkg::ST_OK, read_data: '0, found: 1'b0,
                     position: '0, count: '0};
      mem_wr_addr = slot_of(head_ff, wr_pos);
      mem_rd_addr = slot_of(head_ff, rd_pos);

      unique case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (start) begin
               unique case (act)
                  bdq_pkg::ACT_PUSH_TAIL: begin
                     done = 1'b1;
                     if (full) begin
                        result.status = bdq_pkg::ST_FULL;
                     end else begin
                        wr_pos      = count_ff[PW-1:0];
                        mem_wr_addr = slot_of(head_ff, wr_pos);
                        mem_wr_en   = 1'b1;
                        mem_wr_data = req_value[SW-1:0];
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  bdq_pkg::ACT_PUSH_HEAD: begin
                     done = 1'b1;
                     if (full) begin
                        result.status = bdq_pkg::ST_FULL;
                     end else begin
                        mem_wr_addr = head_m1;
                        mem_wr_en   = 1'b1;
                        mem_wr_data = req_value[SW-1:0];
                        head_in     = head_m1;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  bdq_pkg::ACT_POP_HEAD: begin
                     done = 1'b1;
                     if (empty) begin
                        result.status = bdq_pkg::ST_EMPTY;
                     end else begin
                        head_in  = head_p1;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bdq_pkg::ACT_POP_TAIL: begin
                     done = 1'b1;
                     if (empty) begin
                        result.status = bdq_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bdq_pkg::ACT_READ: begin
                     if (idx_ok) begin
                        rd_pos      = PW'(req_index);
                        mem_rd_addr = slot_of(head_ff, rd_pos);
                        mem_rd_en   = 1'b1;
                     end else begin
                        done          = 1'b1;
                        result.status = bdq_pkg::ST_RANGE;
                     end
                  end
                  bdq_pkg::ACT_DELETE, bdq_pkg::ACT_FIND: begin
                     if (empty) begin
                        done = 1'b1;
                     end
                     val_in    = req_value[SW-1:0];
                     is_del_in = (act == bdq_pkg::ACT_DELETE);
                     rd_pos_in = '0;
                     pend_in   = 1'b0;
                     k_in      = '0;
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         bdq_pkg::S_READ: begin
            done             = 1'b1;
            result.read_data = bdq_pkg::VALUE_W'(mem_rd_data);
         end
         bdq_pkg::S_SCAN: begin
            // Reads run one entry ahead of the compare; the registered RAM output
            // holds the entry at cmp_pos_ff whenever pend_ff is set.
            if (rd_pos_ff < count_ff) begin
               mem_rd_en  = 1'b1;
               rd_pos_in  = rd_pos_ff + CW'(1);
               pend_in    = 1'b1;
               cmp_pos_in = rd_pos_ff[PW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (is_del_ff) begin
                  if (!match) begin
                     mem_wr_en = 1'b1;
                     k_in      = k_ff + CW'(1);
                  end
                  if (last) begin
                     count_in = k_in;
                     done     = 1'b1;
                  end
               end else if (match) begin
                  done            = 1'b1;
                  result.found    = 1'b1;
                  result.position = bdq_pkg::POS_W'(cmp_pos_ff);
               end else if (last) begin
                  done = 1'b1;
               end
            end
         end
         default: ;
      endcase

      result.count = bdq_pkg::COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff     <= val_in;
      is_del_ff  <= is_del_in;
      rd_pos_ff  <= rd_pos_in;
      cmp_pos_ff <= cmp_pos_in;
      k_ff       <= k_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::S_SCAN && mem_wr_en && mem_rd_en) |-> mem_wr_addr != mem_rd_addr)
      else $error("compaction write hits the slot being read");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::S_SCAN && pend_ff) |-> k_ff <= CW'(cmp_pos_ff))
      else $error("compaction write position passed the compare position");

   a_head_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::S_SCAN) |=> $stable(head_ff))
      else $error("head moved during a scan");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == bdq_pkg::S_IDLE)
      else $error("sequencer not idle after a result");
`endif

endmodule

// ----- rtl/bounded_deque_with_value_delete.sv -----
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_stall | req_action, req_value, req_index
// rsp      | out       | rsp_valid / rsp_stall | rsp_status, rsp_read_data, rsp_found,
//          |           |                       | rsp_position, rsp_count
//
// Push, pop, out-of-range read, unused codes and delete or find on an empty deque finish
// in the transfer cycle; a read waits in S_READ for the registered RAM port.
// Delete and find walk the entries through one comparator and one RAM read port;
// a delete walks every entry, a find stops at its first match.
// Reset clears head, count and the sequencer; the entry RAM is not cleared.
// A held result with rsp_stall high blocks further requests.
module bounded_deque_with_value_delete #(
   parameter int DEPTH      = bdq_pkg::DEF_DEPTH,
   parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdq_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_value,
   input  logic [bdq_pkg::INDEX_W-1:0]        req_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [bdq_pkg::VALUE_W-1:0] rsp_read_data,
   output logic                               rsp_found,
   output logic [bdq_pkg::POS_W-1:0]          rsp_position,
   output logic [bdq_pkg::COUNT_W-1:0]        rsp_count
);

   // Only the low SW bits of a value, the smaller of DATA_WIDTH and VALUE_W, are ever stored.
   localparam int SW = (DATA_WIDTH < bdq_pkg::VALUE_W) ? DATA_WIDTH : bdq_pkg::VALUE_W;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                start, busy, done;
   bdq_pkg::result_type result;
   bdq_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                wr_en, rd_en;
   logic [PW-1:0]       wr_addr, rd_addr;
   logic [SW-1:0]       wr_data, rd_data;

   assign req_stall = busy || (rsp_valid_ff && rsp_stall);
   assign start     = req_valid && !req_stall;

   bdq_ctrl #(
      .DEPTH (DEPTH),
      .SW    (SW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_action  (req_action),
      .req_value   (req_value),
      .req_index   (req_index),
      .busy        (busy),
      .done        (done),
      .result      (result),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data)
   );

   bdq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (SW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A new result only arrives once the previous one has been transferred.
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = done ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_found     = rsp_ff.found;
   assign rsp_position  = rsp_ff.position;
   assign rsp_count     = rsp_ff.count;

endmodule

// ----- sim/testbench.sv -----
module testbench;

   localparam int DEPTH = bdq_pkg::DEF_DEPTH;
   localparam logic [bdq_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;

   typedef struct {
      logic [bdq_pkg::ACTION_W-1:0] act;
      logic [bdq_pkg::VALUE_W-1:0]  word;
      logic [bdq_pkg::INDEX_W-1:0]  idx;
   } deque_request_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [bdq_pkg::ACTION_W-1:0]       req_action = '0;
   logic signed [bdq_pkg::VALUE_W-1:0] req_value = '0;
   logic [bdq_pkg::INDEX_W-1:0]        req_index = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [bdq_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [bdq_pkg::VALUE_W-1:0] rsp_read_data;
   logic                               rsp_found;
   logic [bdq_pkg::POS_W-1:0]          rsp_position;
   logic [bdq_pkg::COUNT_W-1:0]        rsp_count;

   deque_request_type           req_backlog[$];
   logic [bdq_pkg::VALUE_W-1:0] stored_words[$];
   bdq_pkg::result_type         pending_results[$];

   logic req_taken = 1'b0;
   bit   mismatch_seen = 1'b0;
   bit   long_hold = 1'b0;
   int   accepted_count = 0;
   int   gap_left = 0;
   int   stall_left = 0;

   bounded_deque_with_value_delete uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_read_data (rsp_read_data),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count)
   );

   always #5 clock = ~clock;

   // Applies one request to the testbench copy of the deque and returns its result.
   function automatic bdq_pkg::result_type deque_effect(logic [bdq_pkg::ACTION_W-1:0] act,
                                                        logic [bdq_pkg::VALUE_W-1:0] word,
                                                        logic [bdq_pkg::INDEX_W-1:0] idx);
      bdq_pkg::result_type         r;
      logic [bdq_pkg::VALUE_W-1:0] kept[$];
      int                          i;
      r = '0;
      case (act)
         bdq_pkg::ACT_PUSH_TAIL: begin
            if (stored_words.size() >= DEPTH) r.status = bdq_pkg::ST_FULL;
            else stored_words.push_back(word);
         end
         bdq_pkg::ACT_PUSH_HEAD: begin
            if (stored_words.size() >= DEPTH) r.status = bdq_pkg::ST_FULL;
            else stored_words.push_front(word);
         end
         bdq_pkg::ACT_POP_HEAD: begin
            if (stored_words.size() == 0) r.status = bdq_pkg::ST_EMPTY;
            else void'(stored_words.pop_front());
         end
         bdq_pkg::ACT_POP_TAIL: begin
            if (stored_words.size() == 0) r.status = bdq_pkg::ST_EMPTY;
            else void'(stored_words.pop_back());
         end
         bdq_pkg::ACT_DELETE: begin
            for (i = 0; i < stored_words.size(); i++)
               if (stored_words[i] != word) kept.push_back(stored_words[i]);
            stored_words = kept;
         end
         bdq_pkg::ACT_READ: begin
            if (int'(idx) >= stored_words.size()) r.status = bdq_pkg::ST_RANGE;
            else r.read_data = stored_words[idx];
         end
         bdq_pkg::ACT_FIND: begin
            for (i = 0; i < stored_words.size(); i++)
               if (!r.found && stored_words[i] == word) begin
                  r.found = 1'b1;
                  r.position = bdq_pkg::POS_W'(i);
               end
         end
         default: ;
      endcase
      r.count = bdq_pkg::COUNT_W'(stored_words.size());
      return r;
   endfunction

   task automatic queue_request(logic [bdq_pkg::ACTION_W-1:0] act,
                                logic [bdq_pkg::VALUE_W-1:0] word,
                                logic [bdq_pkg::INDEX_W-1:0] idx);
      deque_request_type item;
      item.act = act;
      item.word = word;
      item.idx = idx;
      req_backlog.push_back(item);
   endtask

   // Mostly values from a small pool so that delete and find hit stored entries.
   function automatic logic [bdq_pkg::VALUE_W-1:0] pick_word();
      if ($urandom_range(0, 9) >= 6) return $urandom;
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         default: return 32'h0000_0002;
      endcase
   endfunction

   task automatic queue_random_phase(int n, int push_weight);
      int                           roll;
      int                           k;
      logic [bdq_pkg::ACTION_W-1:0] act;
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < push_weight)
            act = $urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL;
         else if (roll < push_weight + 20)
            act = $urandom_range(0, 1) ? bdq_pkg::ACT_POP_HEAD : bdq_pkg::ACT_POP_TAIL;
         else if (roll < push_weight + 28)
            act = bdq_pkg::ACT_DELETE;
         else if (roll < 97)
            act = $urandom_range(0, 1) ? bdq_pkg::ACT_READ : bdq_pkg::ACT_FIND;
         else
            act = ACT_UNUSED;
         queue_request(act, pick_word(), bdq_pkg::INDEX_W'($urandom_range(0, 15)));
      end
   endtask

   // Request driver: a new item is presented only after the previous one transferred.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() >= 40 && $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(1, 13) - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_action <= req_backlog[0].act;
            req_value <= req_backlog[0].word;
            req_index <= req_backlog[0].idx;
            void'(req_backlog.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver stalls in random bursts, plus one long hold-off.
   always @(negedge clock) begin
      if (reset || req_backlog.size() < 40) begin
         rsp_stall <= long_hold;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= long_hold;
      end
   end

   initial begin
      wait (accepted_count >= 120);
      @(posedge clock);
      long_hold = 1'b1;
      repeat (80) @(posedge clock);
      long_hold = 1'b0;
   end

   // Request side: predict each transfer as it happens.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         pending_results.push_back(deque_effect(req_action, req_value, req_index));
         accepted_count <= accepted_count + 1;
      end
   end

   // Result side: compare each transfer with the oldest prediction.
   always @(posedge clock) begin
      bdq_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatch_seen = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_seen = 1'b1;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               mismatch_seen = 1'b1;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               mismatch_seen = 1'b1;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               mismatch_seen = 1'b1;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin
      int i;
      // Pops, delete, find and read on an empty deque first.
      queue_request(bdq_pkg::ACT_POP_HEAD, 32'h0, 4'd0);
      queue_request(bdq_pkg::ACT_POP_TAIL, 32'h0, 4'd0);
      queue_request(bdq_pkg::ACT_DELETE, 32'h0, 4'd0);
      queue_request(bdq_pkg::ACT_FIND, 32'h0, 4'd0);
      queue_request(bdq_pkg::ACT_READ, 32'h0, 4'd0);
      for (i = 0; i < DEPTH; i++) begin
         case (i % 5)
            0: queue_request(i % 2 ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL,
                             32'h8000_0000, 4'd0);
            1: queue_request(i % 2 ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL,
                             32'h7FFF_FFFF, 4'd0);
            2: queue_request(i % 2 ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL,
                             32'h0000_0000, 4'd0);
            3: queue_request(i % 2 ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL,
                             32'hFFFF_FFFF, 4'd0);
            default: queue_request(i % 2 ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL,
                                   32'h5, 4'd0);
         endcase
      end
      // The deque is full now.
      queue_request(bdq_pkg::ACT_PUSH_TAIL, 32'h1234_5678, 4'd0);
      queue_request(bdq_pkg::ACT_PUSH_HEAD, 32'h1234_5678, 4'd0);
      queue_request(bdq_pkg::ACT_READ, 32'h0, 4'd15);
      queue_request(bdq_pkg::ACT_FIND, 32'hFFFF_FFFF, 4'd0);
      queue_request(bdq_pkg::ACT_DELETE, 32'h5, 4'd0);
      queue_request(bdq_pkg::ACT_FIND, 32'h5, 4'd0);
      queue_request(bdq_pkg::ACT_POP_HEAD, 32'h0, 4'd0);
      queue_request(bdq_pkg::ACT_POP_TAIL, 32'h0, 4'd0);
      queue_request(ACT_UNUSED, 32'hFFFF_FFFF, 4'd15);

      queue_random_phase(100, 60);
      queue_random_phase(100, 20);
      queue_random_phase(100, 45);
      queue_random_phase(100, 35);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (!mismatch_seen) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
